/* sv/chd_pkg.sv */
// shared types and constants for the canonical huffman decoder
// no dependencies
package chd_pkg;

	localparam logic [1:0] OP_CLEAR    = 2'd0;
	localparam logic [1:0] OP_LOAD     = 2'd1;
	localparam logic [1:0] OP_FINALIZE = 2'd2;
	localparam logic [1:0] OP_DECODE   = 2'd3;

	localparam int SYM_W = 16;
	localparam int LEN_W = 4;
	localparam int NUM_LENGTHS = 16;

	typedef struct packed {
		logic [1:0]       operation;
		logic [SYM_W-1:0] symbol;
		logic [LEN_W-1:0] code_length;
		logic             code_bit;
	} request_t;

	typedef struct packed {
		logic             decoded_valid;
		logic [SYM_W-1:0] decoded_symbol;
		logic             decode_error;
		logic             table_error;
		logic [LEN_W-1:0] bits_pending;
	} result_t;

endpackage

/* sv/canonical_huffman_decoder_unit.sv */
// top level of the canonical huffman decoder: entry store, table builder, bit decoder
// depends on chd_pkg and chd_ram
//
// usage
// - an item is taken when start is high and busy is low; request.operation picks
//   clear, load (symbol, code_length), finalize or decode one bit (code_bit)
// - every item gives exactly one result on the result port, marked by done for a
//   single cycle; the receiver cannot stall, so the result must be taken then
// - clear, load and a decode bit that completes no code: result the cycle after
//   the item is taken, so one item every 1 cycle
// - a decode bit that completes a code: the symbol passes through the registered
//   read of the sorted symbol memory, then the registered result
// - finalize: sweeps the entry memory once to count lengths, steps one code
//   length per cycle to build first codes, then sweeps the entries again to
//   place symbols; an oversubscribed length set ends it early with table_error
// - reset clears the counters, the per length tables and the ready flag; the
//   entry and sorted memories are not cleared and need no clearing pass
module canonical_huffman_decoder_unit #(
	parameter int MAX_CODE_LENGTH = 15,
	parameter int MAX_SYMBOLS     = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  chd_pkg::request_t request,
	output logic              done,
	output chd_pkg::result_t  result
);

	import chd_pkg::*;

	localparam int AW = $clog2(MAX_SYMBOLS);
	localparam int CW = $clog2(MAX_SYMBOLS + 1);
	localparam int EW = SYM_W + LEN_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_COUNT = 5'b00010,
		S_CODE  = 5'b00100,
		S_PLACE = 5'b01000,
		S_READ  = 5'b10000
	} state_t;

	state_t state_q;

	// loaded entries
	logic [CW-1:0]    entry_count_q;
	logic [SYM_W-1:0] last_sym_q;
	logic             table_ready_q;

	// per length tables
	logic [CW-1:0]    count_q       [NUM_LENGTHS];
	logic [SYM_W-1:0] first_code_q  [NUM_LENGTHS];
	logic [CW-1:0]    first_index_q [NUM_LENGTHS];
	logic [CW-1:0]    placed_q      [NUM_LENGTHS];

	// decoder
	logic [SYM_W-1:0] acc_q;
	logic [LEN_W-1:0] bits_q;

	// table build
	logic [CW-1:0]        sweep_q;
	logic                 rd_pend_s1;
	logic [LEN_W-1:0]     len_q;
	logic signed [17:0]   left_q;
	logic [SYM_W-1:0]     code_q;
	logic [CW-1:0]        index_q;
	logic                 ok_q;

	logic    done_q;
	result_t result_q;

	// memories
	logic [EW-1:0]    ent_rdata;
	logic             ent_we;
	logic [SYM_W-1:0] srt_rdata;
	logic             srt_we;
	logic [AW-1:0]    srt_waddr;
	logic [AW-1:0]    srt_raddr;

	logic [LEN_W-1:0] ent_len;
	logic [SYM_W-1:0] ent_sym;

	// load checks
	logic load_ok;

	// decode datapath
	logic [SYM_W-1:0] acc_n;
	logic [4:0]       n_bits;
	logic             n_in_range;
	logic [SYM_W-1:0] first_n;
	logic [SYM_W:0]   diff_n;
	logic             hit_n;
	logic [SYM_W+1:0] slot_n;
	logic             slot_ok;

	// sweep and code step
	logic               issue;
	logic signed [17:0] left_n;
	logic [SYM_W-1:0]   code_n;
	logic               ok_n;
	logic               place_hit;

	assign ent_len = ent_rdata[LEN_W-1:0];
	assign ent_sym = ent_rdata[EW-1:LEN_W];

	assign load_ok = (entry_count_q < CW'(MAX_SYMBOLS))
		&& (32'(request.code_length) <= 32'(MAX_CODE_LENGTH))
		&& ((entry_count_q == '0) || (request.symbol > last_sym_q));

	assign ent_we = (state_q == S_IDLE) && start && (request.operation == OP_LOAD) && load_ok;

	chd_ram #(.WIDTH(EW), .DEPTH(MAX_SYMBOLS)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (entry_count_q[AW-1:0]),
		.wdata ({request.symbol, request.code_length}),
		.raddr (sweep_q[AW-1:0]),
		.rdata (ent_rdata)
	);

	// symbol placement during the second sweep
	assign place_hit = (state_q == S_PLACE) && rd_pend_s1 && (ent_len != '0)
		&& (placed_q[ent_len] < CW'(MAX_SYMBOLS));
	assign srt_we    = place_hit;
	assign srt_waddr = placed_q[ent_len][AW-1:0];

	chd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_sorted_ram (
		.clk   (clk),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (ent_sym),
		.raddr (srt_raddr),
		.rdata (srt_rdata)
	);

	// one bit of decode: shift in, then match against the code of the new length
	always_comb begin
		acc_n      = {acc_q[SYM_W-2:0], request.code_bit};
		n_bits     = 5'(bits_q) + 5'd1;
		n_in_range = 32'(n_bits) <= 32'(MAX_CODE_LENGTH);
		first_n    = first_code_q[n_bits[3:0]];
		diff_n     = {1'b0, acc_n} - {1'b0, first_n};
		hit_n      = n_in_range && (acc_n >= first_n)
			&& (diff_n < (SYM_W+1)'(count_q[n_bits[3:0]]));
		slot_n     = (SYM_W+2)'(first_index_q[n_bits[3:0]]) + (SYM_W+2)'(diff_n);
		slot_ok    = slot_n < (SYM_W+2)'(MAX_SYMBOLS);
		srt_raddr  = slot_n[AW-1:0];
	end

	// sweep issue and one code length step
	always_comb begin
		issue  = sweep_q < entry_count_q;
		left_n = (left_q <<< 1) - $signed(18'(count_q[len_q]));
		code_n = (code_q + SYM_W'(count_q[len_q - 4'd1])) << 1;
		ok_n   = ok_q && (left_n >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			last_sym_q    <= '0;
			table_ready_q <= 1'b0;
			acc_q         <= '0;
			bits_q        <= '0;
			sweep_q       <= '0;
			rd_pend_s1    <= 1'b0;
			len_q         <= '0;
			left_q        <= '0;
			code_q        <= '0;
			index_q       <= '0;
			ok_q          <= 1'b0;
			done_q        <= 1'b0;
			result_q      <= '0;
			for (int i = 0; i < NUM_LENGTHS; i++) begin
				count_q[i]       <= '0;
				first_code_q[i]  <= '0;
				first_index_q[i] <= '0;
				placed_q[i]      <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					result_q <= '0;
					case (request.operation)
						OP_CLEAR: begin
							entry_count_q <= '0;
							table_ready_q <= 1'b0;
							acc_q         <= '0;
							bits_q        <= '0;
							done_q        <= 1'b1;
						end
						OP_LOAD: begin
							done_q <= 1'b1;
							if (load_ok) begin
								entry_count_q <= entry_count_q + CW'(1);
								last_sym_q    <= request.symbol;
								table_ready_q <= 1'b0;
								acc_q         <= '0;
								bits_q        <= '0;
							end else begin
								result_q.table_error  <= 1'b1;
								result_q.bits_pending <= bits_q;
							end
						end
						OP_FINALIZE: begin
							acc_q      <= '0;
							bits_q     <= '0;
							sweep_q    <= '0;
							rd_pend_s1 <= 1'b0;
							for (int i = 0; i < NUM_LENGTHS; i++) begin
								count_q[i] <= '0;
							end
							state_q <= S_COUNT;
						end
						OP_DECODE: begin
							if (!table_ready_q) begin
								done_q                <= 1'b1;
								result_q.decode_error <= 1'b1;
								result_q.bits_pending <= bits_q;
							end else if (hit_n && slot_ok) begin
								// symbol comes from the sorted memory next cycle
								acc_q   <= '0;
								bits_q  <= '0;
								state_q <= S_READ;
							end else if (hit_n || !n_in_range
								|| (32'(n_bits) >= 32'(MAX_CODE_LENGTH))) begin
								done_q                <= 1'b1;
								result_q.decode_error <= 1'b1;
								acc_q                 <= '0;
								bits_q                <= '0;
							end else begin
								done_q                <= 1'b1;
								acc_q                 <= acc_n;
								bits_q                <= n_bits[3:0];
								result_q.bits_pending <= n_bits[3:0];
							end
						end
						default: begin
							done_q <= 1'b1;
						end
					endcase
				end
				S_READ: begin
					done_q                  <= 1'b1;
					result_q.decoded_valid  <= 1'b1;
					result_q.decoded_symbol <= srt_rdata;
					state_q                 <= S_IDLE;
				end
				S_COUNT: begin
					rd_pend_s1 <= issue;
					if (issue) begin
						sweep_q <= sweep_q + CW'(1);
					end
					if (rd_pend_s1 && (ent_len != '0)) begin
						count_q[ent_len] <= count_q[ent_len] + CW'(1);
					end
					if (!issue && !rd_pend_s1) begin
						len_q   <= 4'd1;
						left_q  <= 18'sd1;
						code_q  <= '0;
						index_q <= '0;
						ok_q    <= 1'b1;
						state_q <= S_CODE;
					end
				end
				S_CODE: begin
					left_q               <= left_n;
					ok_q                 <= ok_n;
					code_q               <= code_n;
					first_code_q[len_q]  <= code_n;
					first_index_q[len_q] <= index_q;
					placed_q[len_q]      <= index_q;
					index_q              <= index_q + count_q[len_q];
					len_q                <= len_q + 4'd1;
					if (32'(len_q) == 32'(MAX_CODE_LENGTH)) begin
						if (ok_n) begin
							sweep_q    <= '0;
							rd_pend_s1 <= 1'b0;
							state_q    <= S_PLACE;
						end else begin
							table_ready_q        <= 1'b0;
							done_q               <= 1'b1;
							result_q.table_error <= 1'b1;
							state_q              <= S_IDLE;
						end
					end
				end
				S_PLACE: begin
					rd_pend_s1 <= issue;
					if (issue) begin
						sweep_q <= sweep_q + CW'(1);
					end
					if (place_hit) begin
						placed_q[ent_len] <= placed_q[ent_len] + CW'(1);
					end
					if (!issue && !rd_pend_s1) begin
						table_ready_q <= 1'b1;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* sv/chd_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module chd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
